>>> rtl/vdbac_pkg.sv
// Shared types, constants and microcode program for the voice DC blocker,
// band-pass biquad and AGC chain. No dependencies.
package vdbac_pkg;

  localparam int STEP_W    = 4;
  localparam int ACC_W     = 40;
  localparam int OPA_W     = 36;
  localparam int OPB_W     = 17;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [STEP_W-1:0] STEP_IDLE = '0;
  localparam logic [STEP_W-1:0] STEP_LAST = '1;

  localparam logic signed [OPB_W-1:0] DC_ALPHA = 17'sd32440;

  localparam logic signed [ACC_W-1:0] ACC_GAIN_MIN = 40'sd3276;
  localparam logic signed [ACC_W-1:0] ACC_GAIN_MAX = 40'sd327680;
  localparam logic signed [ACC_W-1:0] ACC_SAT_MAX  = 40'sd32767;
  localparam logic signed [ACC_W-1:0] ACC_SAT_MIN  = -40'sd32768;
  localparam logic [18:0]             GAIN_UNITY   = 19'd32768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_BAND_GAIN, REG_AGC_TARGET, REG_GAIN_STEP
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] coef_b0;
    logic signed [15:0] coef_b1;
    logic signed [15:0] coef_b2;
    logic signed [15:0] coef_a1;
    logic signed [15:0] coef_a2;
    logic [14:0]        band_gain;
    logic [14:0]        agc_target;
    logic [14:0]        gain_step;
  } cfg_t;

  // Multiplier operand sources
  typedef enum logic [2:0] {
    A_DC_OUT, A_D1, A_D2, A_W, A_ACC, A_ERR, A_S2
  } a_sel_t;

  typedef enum logic [3:0] {
    B_ALPHA, B_B0, B_B1, B_B2, B_A1, B_A2, B_BAND, B_RATE, B_GAIN_HI
  } b_sel_t;

  // Accumulator operations on the shifted product
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD_DCX, ACC_ADD, ACC_SUB, ACC_SATSUB, ACC_LOAD, ACC_LOAD_SAT, ACC_ADD_GAIN
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0, SH_7, SH_15
  } shift_t;

  // State register writes
  typedef enum logic [2:0] {
    ST_NONE, ST_IN, ST_DC, ST_W, ST_DELAY, ST_S2, ST_GAIN, ST_OUT
  } store_t;

  typedef enum logic [1:0] {
    J_NEXT, J_WAIT_IN, J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    a_sel_t             a_sel;
    b_sel_t             b_sel;
    acc_op_t            acc_op;
    shift_t             shift;
    store_t             store;
    jmp_t               jmp;
    logic [STEP_W-1:0]  target;
  } ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_SAT_MAX) r = 16'sh7FFF;
    else if (v < ACC_SAT_MIN) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic ctrl_t make_word(input a_sel_t a, input b_sel_t b, input acc_op_t op,
                                      input shift_t sh, input store_t st, input jmp_t j);
    ctrl_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.shift  = sh;
    w.store  = st;
    w.jmp    = j;
    w.target = STEP_IDLE;
    return w;
  endfunction

  // Program: each step issues a product and may accumulate the previous one.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      4'd0:  w = make_word(A_DC_OUT, B_ALPHA,   ACC_HOLD,     SH_15, ST_IN,    J_WAIT_IN);
      4'd1:  w = make_word(A_DC_OUT, B_ALPHA,   ACC_LOAD_DCX, SH_15, ST_NONE,  J_NEXT);
      4'd2:  w = make_word(A_D1,     B_A1,      ACC_ADD,      SH_15, ST_NONE,  J_NEXT);
      4'd3:  w = make_word(A_D2,     B_A2,      ACC_SATSUB,   SH_15, ST_DC,    J_NEXT);
      4'd4:  w = make_word(A_D1,     B_B1,      ACC_SUB,      SH_15, ST_NONE,  J_NEXT);
      4'd5:  w = make_word(A_D2,     B_B2,      ACC_LOAD,     SH_15, ST_W,     J_NEXT);
      4'd6:  w = make_word(A_W,      B_B0,      ACC_ADD,      SH_15, ST_DELAY, J_NEXT);
      4'd7:  w = make_word(A_W,      B_B0,      ACC_ADD,      SH_15, ST_NONE,  J_NEXT);
      4'd8:  w = make_word(A_ACC,    B_BAND,    ACC_HOLD,     SH_15, ST_NONE,  J_NEXT);
      4'd9:  w = make_word(A_ACC,    B_BAND,    ACC_LOAD_SAT, SH_15, ST_NONE,  J_NEXT);
      4'd10: w = make_word(A_ERR,    B_RATE,    ACC_HOLD,     SH_0,  ST_S2,    J_NEXT);
      4'd11: w = make_word(A_ERR,    B_RATE,    ACC_ADD_GAIN, SH_0,  ST_NONE,  J_NEXT);
      4'd12: w = make_word(A_S2,     B_GAIN_HI, ACC_HOLD,     SH_0,  ST_GAIN,  J_NEXT);
      4'd13: w = make_word(A_S2,     B_GAIN_HI, ACC_HOLD,     SH_7,  ST_NONE,  J_NEXT);
      4'd14: w = make_word(A_S2,     B_GAIN_HI, ACC_LOAD_SAT, SH_7,  ST_NONE,  J_NEXT);
      4'd15: w = make_word(A_S2,     B_GAIN_HI, ACC_HOLD,     SH_7,  ST_OUT,   J_WAIT_OUT);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/voice_dc_bandpass_agc_chain_top.sv
// Voice chain: one-pole DC blocker, Q15 biquad with band gain, AGC.
// The program is 16 steps on one shared multiplier and accumulator, so a new item
// is taken only at step 0; the final step waits while the output is stalled.
// Reset (rst, synchronous): clears filter state, sets AGC gain to unity and
// loads the default coefficients; no clearing pass.
module voice_dc_bandpass_agc_chain_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  mic_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_sample,
  input  logic                                cfg_we,
  input  logic [vdbac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vdbac_pkg::CFG_W-1:0]         cfg_data
);
  import vdbac_pkg::*;

  cfg_t  cfg;
  ctrl_t ctl;

  // Configuration registers: the user must write them only while the chain is
  // idle, so the datapath sees stable coefficients for a whole item; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_b0    <= 16'sd15136;
      cfg.coef_b1    <= 16'sd0;
      cfg.coef_b2    <= -16'sd15136;
      cfg.coef_a1    <= 16'sd25078;
      cfg.coef_a2    <= 16'sd17630;
      cfg.band_gain  <= 15'd18000;
      cfg.agc_target <= 15'd24576;
      cfg.gain_step  <= 15'd163;
    end else if (cfg_we) begin
      // Registers narrower than the data word drop the high bits
      unique case (reg_idx_t'(cfg_index))
        REG_B0:         cfg.coef_b0    <= cfg_data;
        REG_B1:         cfg.coef_b1    <= cfg_data;
        REG_B2:         cfg.coef_b2    <= cfg_data;
        REG_A1:         cfg.coef_a1    <= cfg_data;
        REG_A2:         cfg.coef_a2    <= cfg_data;
        REG_BAND_GAIN:  cfg.band_gain  <= cfg_data[14:0];
        REG_AGC_TARGET: cfg.agc_target <= cfg_data[14:0];
        REG_GAIN_STEP:  cfg.gain_step  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Step counter and program table; hold the input while a program runs,
  // hold the final step until the output register is free.
  vdbac_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Shared multiply/accumulate datapath with the filter and AGC state
  vdbac_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .mic_sample (mic_sample),
    .out_sample (out_sample)
  );

endmodule

>>> rtl/vdbac_seq.sv
// Microcode sequencer: step counter, program table, wait/jump handling and
// output valid flag. Depends on vdbac_pkg.
module vdbac_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output vdbac_pkg::ctrl_t ctl
);
  import vdbac_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctrl_t             word;
  logic              accept;
  logic              out_free;

  assign word     = rom_word(pc);
  assign in_stall = (word.jmp != J_WAIT_IN);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    pc_next = pc;
    ctl     = word;
    unique case (word.jmp)
      J_NEXT: pc_next = pc + 1'b1;
      J_WAIT_IN: begin
        if (accept) pc_next = pc + 1'b1;
        else ctl.store = ST_NONE;
      end
      J_WAIT_OUT: begin
        if (out_free) pc_next = word.target;
        else ctl.store = ST_NONE;
      end
      default: pc_next = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (word.jmp == J_WAIT_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    accept |=> pc == STEP_IDLE + 1'b1)
    else $error("accepted item did not start the program");

  a_steps_advance : assert property (@(posedge clk) disable iff (rst)
    (pc != STEP_IDLE && pc != STEP_LAST) |=> pc == STEP_W'($past(pc) + 1'b1))
    else $error("step counter skipped or held mid-program");

  a_result_at_end : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == STEP_LAST)
    else $error("result raised outside the final step");

endmodule

>>> rtl/vdbac_dp.sv
// Datapath: shared multiplier with product register, accumulator and the
// filter/AGC state registers. Driven by the control word. Depends on vdbac_pkg.
module vdbac_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  vdbac_pkg::ctrl_t         ctl,
  input  vdbac_pkg::cfg_t          cfg,
  input  logic signed [15:0]       mic_sample,
  output logic signed [15:0]       out_sample
);
  import vdbac_pkg::*;

  logic signed [15:0]       x;
  logic signed [15:0]       dc_last_in;
  logic signed [17:0]       dc_last_out;
  logic signed [31:0]       d1;
  logic signed [31:0]       d2;
  logic signed [31:0]       w;
  logic signed [15:0]       s2;
  logic [18:0]              gain;
  logic signed [PROD_W-1:0] p;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  ps;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [15:0]       acc16;
  logic [14:0]              mag;
  logic signed [15:0]       err;
  logic [18:0]              gain_clamped;

  // Magnitude of the band output, with the most negative code taken as 32767
  assign acc16 = acc[15:0];
  always_comb begin
    if (!acc16[15]) mag = acc16[14:0];
    else if (acc16 == -16'sh8000) mag = 15'h7FFF;
    else mag = 15'(-acc16);
  end
  assign err = $signed({1'b0, cfg.agc_target}) - $signed({1'b0, mag});

  always_comb begin
    if (acc < ACC_GAIN_MIN) gain_clamped = ACC_GAIN_MIN[18:0];
    else if (acc > ACC_GAIN_MAX) gain_clamped = ACC_GAIN_MAX[18:0];
    else gain_clamped = acc[18:0];
  end

  always_comb begin
    unique case (ctl.a_sel)
      A_DC_OUT: op_a = {{(OPA_W-18){dc_last_out[17]}}, dc_last_out};
      A_D1:     op_a = {{(OPA_W-32){d1[31]}}, d1};
      A_D2:     op_a = {{(OPA_W-32){d2[31]}}, d2};
      A_W:      op_a = {{(OPA_W-32){w[31]}}, w};
      A_ACC:    op_a = acc[OPA_W-1:0];
      A_ERR:    op_a = {{(OPA_W-16){err[15]}}, err};
      A_S2:     op_a = {{(OPA_W-16){s2[15]}}, s2};
      default:  op_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.b_sel)
      B_ALPHA:   op_b = DC_ALPHA;
      B_B0:      op_b = {cfg.coef_b0[15], cfg.coef_b0};
      B_B1:      op_b = {cfg.coef_b1[15], cfg.coef_b1};
      B_B2:      op_b = {cfg.coef_b2[15], cfg.coef_b2};
      B_A1:      op_b = {cfg.coef_a1[15], cfg.coef_a1};
      B_A2:      op_b = {cfg.coef_a2[15], cfg.coef_a2};
      B_BAND:    op_b = {2'b00, cfg.band_gain};
      B_RATE:    op_b = {2'b00, cfg.gain_step};
      B_GAIN_HI: op_b = {6'd0, gain[18:8]};
      default:   op_b = '0;
    endcase
  end

  // Floor shift of the registered product
  always_comb begin
    unique case (ctl.shift)
      SH_0:    ps = p[ACC_W-1:0];
      SH_7:    ps = p[ACC_W+6:7];
      SH_15:   ps = {{(ACC_W-(PROD_W-15)){p[PROD_W-1]}}, p[PROD_W-1:15]};
      default: ps = p[ACC_W-1:0];
    endcase
  end

  always_comb begin
    unique case (ctl.acc_op)
      ACC_HOLD:     acc_next = acc;
      ACC_LOAD_DCX: acc_next = ACC_W'(x) - ACC_W'(dc_last_in);
      ACC_ADD:      acc_next = acc + ps;
      ACC_SUB:      acc_next = acc - ps;
      ACC_SATSUB:   acc_next = ACC_W'(sat16(acc)) - ps;
      ACC_LOAD:     acc_next = ps;
      ACC_LOAD_SAT: acc_next = ACC_W'(sat16(ps));
      ACC_ADD_GAIN: acc_next = $signed({{(ACC_W-19){1'b0}}, gain}) + ps;
      default:      acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    p   <= op_a * op_b;
    acc <= acc_next;
    if (rst) begin
      dc_last_in  <= '0;
      dc_last_out <= '0;
      d1          <= '0;
      d2          <= '0;
      gain        <= GAIN_UNITY;
    end else begin
      unique case (ctl.store)
        ST_NONE: ;
        ST_IN:   x <= mic_sample;
        ST_DC: begin
          dc_last_in  <= x;
          dc_last_out <= acc[17:0];
        end
        ST_W:    w <= acc[31:0];
        ST_DELAY: begin
          d2 <= d1;
          d1 <= w;
        end
        ST_S2:   s2 <= acc[15:0];
        ST_GAIN: gain <= gain_clamped;
        ST_OUT:  out_sample <= acc[15:0];
        default: ;
      endcase
    end
  end

  a_gain_range : assert property (@(posedge clk) disable iff (rst)
    (gain >= ACC_GAIN_MIN[18:0]) && (gain <= ACC_GAIN_MAX[18:0]))
    else $error("AGC gain left its clamp range");

  a_out_saturated : assert property (@(posedge clk) disable iff (rst)
    (ctl.store == ST_OUT) |=> out_sample == $past(acc[15:0]))
    else $error("output register not loaded from the accumulator");

endmodule

>>> dv/voice_dc_bandpass_agc_chain_top_tb.sv
// Self-checking testbench for the voice DC blocker, band-pass biquad and AGC chain.
// Uses vdbac_pkg for the register index enum and rtl/voice_dc_bandpass_agc_chain_top.sv.
// A directed table is followed by random samples under several register settings.
module voice_dc_bandpass_agc_chain_top_tb;
  import vdbac_pkg::*;

  localparam int  DIR_ROWS        = 30;
  localparam int  PHASES          = 8;
  localparam int  ITEMS_PER_PHASE = 140;
  localparam int  TIMEOUT         = 4_000_000;

  localparam longint POLE_ALPHA = 32440;
  localparam longint S16_MAX    = 32767;
  localparam longint S16_MIN    = -32768;
  localparam longint GAIN_FLOOR = 3276;
  localparam longint GAIN_CEIL  = 327680;

  // Register values after reset, in index order
  localparam logic [15:0] DEFAULT_REGS [8] = '{16'd15136, 16'd0, 16'hC4E0, 16'd25078,
                                               16'd17630, 16'd18000, 16'd24576, 16'd163};

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  // One directed row: a sample to send, or a register write. For a sample row,
  // typed marks a result that is known by inspection and given in want.
  typedef struct {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [15:0]        value;
    logic               typed;
    logic signed [15:0] want;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic signed [15:0] mic_sample = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_index  = '0;
  logic [15:0]        cfg_data   = '0;

  idle_mode_t         idle_mode = IDLE_NONE;
  int                 mismatch_count = 0;
  logic signed [15:0] pending_out [$];
  logic signed [15:0] walk_level = '0;

  // Chain state and register copies for prediction
  longint dc_prev_in  = 0;
  longint dc_prev_out = 0;
  longint bq_w1       = 0;
  longint bq_w2       = 0;
  longint agc_level   = 32768;
  longint cfg_b0      = 15136;
  longint cfg_b1      = 0;
  longint cfg_b2      = -15136;
  longint cfg_a1      = 25078;
  longint cfg_a2      = 17630;
  longint cfg_band    = 18000;
  longint cfg_target  = 24576;
  longint cfg_rate    = 163;

  voice_dc_bandpass_agc_chain_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mic_sample (mic_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed stimulus: zeros straight after reset, full-scale steps, a zero band
  // gain that silences the output, the top register bit that must be dropped,
  // a driven AGC floor, feedback coefficients that make the biquad delay wrap,
  // and the most negative sample reaching the AGC magnitude.
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_SAMPLE, REG_B0,         16'h0000, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h0000, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h0001, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'hFFFF, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_BAND_GAIN,  16'h0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h3039, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b1, 16'sh0000},
    '{ROW_REG,    REG_BAND_GAIN,  16'hFFFF, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_AGC_TARGET, 16'h0000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_GAIN_STEP,  16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_A1,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_A2,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_B1,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_B2,         16'hFFFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h0000, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_AGC_TARGET, 16'hFFFF, 1'b0, 16'sh0000},
    '{ROW_REG,    REG_GAIN_STEP,  16'hFFFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, REG_B0,         16'h1234, 1'b0, 16'sh0000}
  };

  function automatic longint clip16(input longint v);
    if (v > S16_MAX) return S16_MAX;
    if (v < S16_MIN) return S16_MIN;
    return v;
  endfunction

  // Advance the chain state by one sample and return the processed sample.
  function automatic logic signed [15:0] predict_chain(input logic signed [15:0] mic);
    longint x, dc, w, y, s2, mag, g;
    x = longint'(mic);
    dc = ((POLE_ALPHA * dc_prev_out) >>> 15) + x - dc_prev_in;
    dc_prev_in = x;
    dc_prev_out = dc;
    // Direct form II on the saturated blocker output; w wraps at 32 bits.
    w = clip16(dc) - ((cfg_a1 * bq_w1) >>> 15) - ((cfg_a2 * bq_w2) >>> 15);
    w = longint'($signed(w[31:0]));
    y = ((cfg_b0 * w) >>> 15) + ((cfg_b1 * bq_w1) >>> 15) + ((cfg_b2 * bq_w2) >>> 15);
    bq_w2 = bq_w1;
    bq_w1 = w;
    s2 = clip16((y * cfg_band) >>> 15);
    // AGC: the magnitude of the most negative sample counts as full positive scale.
    mag = (s2 < 0) ? -s2 : s2;
    if (mag > S16_MAX) mag = S16_MAX;
    g = agc_level + cfg_rate * (cfg_target - mag);
    if (g < GAIN_FLOOR) g = GAIN_FLOOR;
    if (g > GAIN_CEIL) g = GAIN_CEIL;
    agc_level = g;
    return 16'(clip16((s2 * (g >>> 8)) >>> 7));
  endfunction

  function automatic int idle_pct(input logic receiver_side);
    case (idle_mode)
      IDLE_SENDER:   return receiver_side ? 0 : 76;
      IDLE_RECEIVER: return receiver_side ? 76 : 0;
      IDLE_BOTH:     return 10;
      default:       return 0;
    endcase
  endfunction

  // Mix full-scale values, tiny values around zero, a slow random walk that lets
  // the AGC settle, and uniformly random samples.
  function automatic logic signed [15:0] next_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      3, 4, 5: begin
        walk_level = walk_level + 16'(int'($urandom_range(0, 4096)) - 2048);
        return walk_level;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Register settings per phase: reset values, all at the top, all at the bottom,
  // then random ones, with the feedback kept modest about half the time.
  function automatic logic [15:0] phase_value(input int phase, input reg_idx_t idx);
    case (phase)
      0: return DEFAULT_REGS[idx];
      1: return (idx <= REG_A2) ? 16'h7FFF : 16'hFFFF;
      2: return (idx <= REG_A2) ? 16'h8000 : 16'h0000;
      default: begin
        if ((idx == REG_A1 || idx == REG_A2) && $urandom_range(0, 1) == 1)
          return 16'(int'($urandom_range(0, 16383)) - 8192);
        if (idx == REG_GAIN_STEP && $urandom_range(0, 1) == 1)
          return 16'($urandom_range(0, 400));
        return 16'($urandom);
      end
    endcase
  endfunction

  // Write one register and mirror it; the caller lowers cfg_we after the last write.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_B0:         cfg_b0 = longint'($signed(value));
      REG_B1:         cfg_b1 = longint'($signed(value));
      REG_B2:         cfg_b2 = longint'($signed(value));
      REG_A1:         cfg_a1 = longint'($signed(value));
      REG_A2:         cfg_a2 = longint'($signed(value));
      REG_BAND_GAIN:  cfg_band = longint'(value[14:0]);
      REG_AGC_TARGET: cfg_target = longint'(value[14:0]);
      REG_GAIN_STEP:  cfg_rate = longint'(value[14:0]);
      default: ;
    endcase
  endtask

  // Offer one item after a random gap and hold it until accepted. Keep
  // in_valid high on return so back-to-back items follow without it dropping.
  task automatic send_sample(input logic signed [15:0] s, input logic typed,
                             input logic signed [15:0] want);
    logic signed [15:0] predicted;
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mic_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_chain(s);
    pending_out.push_back(typed ? want : predicted);
  endtask

  // Drop in_valid and hold until every pending result has come out; the block
  // is then back at its first step and safe to reconfigure.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  // Output side: check the item taken at this edge, then pick the next stall.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        $display("%0t: out_sample expected none, got %0d", $time, out_sample);
        mismatch_count++;
      end else begin
        want = pending_out.pop_front();
        if (out_sample !== want) begin
          $display("%0t: out_sample expected %0d, got %0d", $time, want, out_sample);
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; register writes wait for the block to go idle.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_REG) begin
        if (r == 0 || dir_table[r-1].kind != ROW_REG) drain_results();
        write_reg(dir_table[r].idx, dir_table[r].value);
        if (r + 1 == DIR_ROWS || dir_table[r+1].kind != ROW_REG) cfg_we <= 1'b0;
      end else begin
        send_sample(dir_table[r].value, dir_table[r].typed, dir_table[r].want);
      end
    end

    // Random phases: rotate the idling pattern and reload every register.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      idle_mode = idle_mode_t'(p % 4);
      for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), phase_value(p, reg_idx_t'(k)));
      cfg_we <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(next_sample(), 1'b0, 16'sh0000);
    end

    drain_results();
    // Allow one more pass of the program so a stray extra result is caught.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/vdbac_pkg.sv
rtl/vdbac_seq.sv
rtl/vdbac_dp.sv
rtl/voice_dc_bandpass_agc_chain_top.sv
dv/voice_dc_bandpass_agc_chain_top_tb.sv
